// File: hdl/sta_pkg.sv
// package for the sparse triplet accumulate block
// holds field widths, mode and status codes, and the controller/datapath structs
// no dependencies
package sta_pkg;

  localparam int MODE_W = 3;
  localparam int ROW_W  = 16;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 7;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 7;
  localparam int CNT_W  = 8;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MATCH  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd3;

  // which result the datapath loads into the output register this cycle
  typedef enum logic [2:0] {
    RES_HOLD,
    RES_UPDATE,
    RES_APPEND,
    RES_READ,
    RES_BEYOND,
    RES_CLEAR,
    RES_EMPTY
  } res_kind_t;

  typedef struct packed {
    logic      load_op;
    logic      scan_start;
    logic      scan_issue;
    logic      read_issue;
    res_kind_t res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              idx_ok;
    logic              hit;
    logic              last;
  } dp_status_t;

endpackage

// File: hdl/sta_ctrl.sv
// controller state machine for the sparse triplet accumulate block
// sequences dispatch, table scan and result load; depends on sta_pkg
module sta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sta_pkg::dp_status_t status,
  output sta_pkg::ctrl_cmd_t  cmd
);
  import sta_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_UPDATE,
    S_APPEND,
    S_READ,
    S_BEYOND,
    S_CLEAR,
    S_EMPTY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd.load_op    = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_issue = 1'b0;
    cmd.read_issue = 1'b0;
    cmd.res        = RES_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.mode) inside
          MODE_APPEND: state_nxt = S_APPEND;
          MODE_ADD, MODE_SUB: begin
            if (status.cnt_zero) begin
              state_nxt = S_APPEND;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          MODE_READ: begin
            if (status.idx_ok) begin
              cmd.read_issue = 1'b1;
              state_nxt      = S_READ;
            end else begin
              state_nxt = S_BEYOND;
            end
          end
          MODE_CLEAR: state_nxt = S_CLEAR;
          default:    state_nxt = S_EMPTY;
        endcase
      end
      S_SCAN: begin
        // hold the read data once the entry matches
        cmd.scan_issue = !status.hit;
        if (status.hit) begin
          state_nxt = S_UPDATE;
        end else if (status.last) begin
          state_nxt = S_APPEND;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          cmd.res   = RES_UPDATE;
          state_nxt = S_IDLE;
        end
      end
      S_APPEND: begin
        if (out_free) begin
          cmd.res   = RES_APPEND;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.res   = RES_READ;
          state_nxt = S_IDLE;
        end
      end
      S_BEYOND: begin
        if (out_free) begin
          cmd.res   = RES_BEYOND;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (out_free) begin
          cmd.res   = RES_CLEAR;
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          cmd.res   = RES_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.res != RES_HOLD) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res != RES_HOLD) |-> out_free)
    else $error("result loaded over a pending transfer");

  a_hit_goes_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && status.hit) |=> (state_r == S_UPDATE))
    else $error("scan match did not lead to update");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_op, cmd.scan_issue, cmd.read_issue, cmd.scan_start}))
    else $error("conflicting datapath commands");
`endif

endmodule

// File: hdl/sta_dpath.sv
// datapath for the sparse triplet accumulate block
// triplet memory, scan pointers, accumulate adder and output register; depends on sta_pkg
module sta_dpath #(
  parameter int ENTRIES = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sta_pkg::MODE_W-1:0]        in_mode,
  input  logic [sta_pkg::ROW_W-1:0]         in_row,
  input  logic [sta_pkg::ROW_W-1:0]         in_col,
  input  logic signed [sta_pkg::VAL_W-1:0]  in_value,
  input  logic [sta_pkg::IDX_W-1:0]         in_index,
  input  sta_pkg::ctrl_cmd_t                cmd,
  output sta_pkg::dp_status_t               status,
  output logic [sta_pkg::STAT_W-1:0]        out_status,
  output logic [sta_pkg::SLOT_W-1:0]        out_slot,
  output logic [sta_pkg::ROW_W-1:0]         out_row,
  output logic [sta_pkg::ROW_W-1:0]         out_col,
  output logic signed [sta_pkg::VAL_W-1:0]  out_value,
  output logic [sta_pkg::CNT_W-1:0]         out_entry_count
);
  import sta_pkg::*;

  localparam int AW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int CMPW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int WORD_W = 2 * ROW_W + VAL_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  logic [WORD_W-1:0] mem [ENTRIES];

  logic [MODE_W-1:0] op_mode_r;
  logic [ROW_W-1:0]  op_row_r;
  logic [ROW_W-1:0]  op_col_r;
  logic [VAL_W-1:0]  op_value_r;
  logic [IDX_W-1:0]  op_index_r;

  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_ptr_r;
  logic [AW-1:0]     cmp_ptr_r;
  logic              rd_valid_r;
  logic [WORD_W-1:0] rd_data_r;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [ROW_W-1:0]  res_row_r, res_row_nxt;
  logic [ROW_W-1:0]  res_col_r, res_col_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;

  logic              scan_rd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;

  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  rd_col;
  logic [VAL_W-1:0]  rd_val;
  logic [VAL_W-1:0]  acc_val;
  logic [VAL_W-1:0]  push_val;
  logic              full;

  assign rd_row = rd_data_r[WORD_W-1 -: ROW_W];
  assign rd_col = rd_data_r[VAL_W +: ROW_W];
  assign rd_val = rd_data_r[VAL_W-1:0];

  assign full     = (count_r == FULL_COUNT);
  assign acc_val  = (op_mode_r == MODE_ADD) ? (rd_val + op_value_r) : (rd_val - op_value_r);
  assign push_val = (op_mode_r == MODE_SUB) ? (-op_value_r) : op_value_r;

  assign scan_rd = cmd.scan_issue && (rd_ptr_r < count_r);
  assign mem_re  = scan_rd || cmd.read_issue;
  assign mem_ra  = cmd.read_issue ? AW'(op_index_r) : rd_ptr_r[AW-1:0];

  assign status.mode     = op_mode_r;
  assign status.cnt_zero = (count_r == '0);
  assign status.idx_ok   = (CMPW'(op_index_r) < CMPW'(count_r));
  assign status.hit      = rd_valid_r && (rd_row == op_row_r) && (rd_col == op_col_r);
  assign status.last     = rd_valid_r && ((CW'(cmp_ptr_r) + CW'(1)) == count_r);

  always_comb begin
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_row_nxt    = res_row_r;
    res_col_nxt    = res_col_r;
    res_value_nxt  = res_value_r;
    res_count_nxt  = res_count_r;
    mem_we         = 1'b0;
    mem_wa         = cmp_ptr_r;
    mem_wd         = {op_row_r, op_col_r, acc_val};
    unique case (cmd.res)
      RES_HOLD: begin
      end
      RES_UPDATE: begin
        mem_we         = 1'b1;
        res_status_nxt = STAT_MATCH;
        res_slot_nxt   = SLOT_W'(cmp_ptr_r);
        res_row_nxt    = op_row_r;
        res_col_nxt    = op_col_r;
        res_value_nxt  = acc_val;
        res_count_nxt  = CNT_W'(count_r);
      end
      RES_APPEND: begin
        if (full) begin
          res_status_nxt = STAT_FULL;
          res_slot_nxt   = '0;
          res_row_nxt    = '0;
          res_col_nxt    = '0;
          res_value_nxt  = '0;
          res_count_nxt  = CNT_W'(count_r);
        end else begin
          mem_we         = 1'b1;
          mem_wa         = count_r[AW-1:0];
          mem_wd         = {op_row_r, op_col_r, push_val};
          count_nxt      = count_r + CW'(1);
          res_status_nxt = STAT_OK;
          res_slot_nxt   = SLOT_W'(count_r);
          res_row_nxt    = op_row_r;
          res_col_nxt    = op_col_r;
          res_value_nxt  = push_val;
          res_count_nxt  = CNT_W'(count_r + CW'(1));
        end
      end
      RES_READ: begin
        res_status_nxt = STAT_OK;
        res_slot_nxt   = SLOT_W'(op_index_r);
        res_row_nxt    = rd_row;
        res_col_nxt    = rd_col;
        res_value_nxt  = rd_val;
        res_count_nxt  = CNT_W'(count_r);
      end
      RES_BEYOND: begin
        res_status_nxt = STAT_BEYOND;
        res_slot_nxt   = SLOT_W'(op_index_r);
        res_row_nxt    = '0;
        res_col_nxt    = '0;
        res_value_nxt  = '0;
        res_count_nxt  = CNT_W'(count_r);
      end
      RES_CLEAR: begin
        count_nxt      = '0;
        res_status_nxt = STAT_OK;
        res_slot_nxt   = '0;
        res_row_nxt    = '0;
        res_col_nxt    = '0;
        res_value_nxt  = '0;
        res_count_nxt  = '0;
      end
      default: begin
        res_status_nxt = STAT_OK;
        res_slot_nxt   = '0;
        res_row_nxt    = '0;
        res_col_nxt    = '0;
        res_value_nxt  = '0;
        res_count_nxt  = CNT_W'(count_r);
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rd_ptr_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.scan_start) begin
        rd_ptr_r   <= '0;
        rd_valid_r <= 1'b0;
      end else if (scan_rd) begin
        rd_ptr_r   <= rd_ptr_r + CW'(1);
        rd_valid_r <= 1'b1;
      end else begin
        rd_valid_r <= 1'b0;
      end
    end
  end

  // operand and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_mode_r  <= in_mode;
      op_row_r   <= in_row;
      op_col_r   <= in_col;
      op_value_r <= in_value;
      op_index_r <= in_index;
    end
    if (scan_rd) begin
      cmp_ptr_r <= rd_ptr_r[AW-1:0];
    end
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_row_r    <= res_row_nxt;
    res_col_r    <= res_col_nxt;
    res_value_r  <= res_value_nxt;
    res_count_r  <= res_count_nxt;
  end

  // triplet memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  assign out_status      = res_status_r;
  assign out_slot        = res_slot_r;
  assign out_row         = res_row_r;
  assign out_col         = res_col_r;
  assign out_value       = res_value_r;
  assign out_entry_count = res_count_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above table size");

  a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (CW'(cmp_ptr_r) < count_r))
    else $error("scan compared a slot beyond the count");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res == RES_APPEND && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not grow the table");
`endif

endmodule

// File: hdl/sparse_triplet_accumulate.sv
// sequence: append, read, clear and unused modes go from the transfer through dispatch to their
// result-load state, which raises out_valid; add and subtract on a non-empty table scan first: the scan
// compares one stored entry per cycle through the single registered read port
// flow: one item in work at a time, the next transfer is taken the cycle after the
// result loads; a waiting result only holds the load
// reset: synchronous active-low rst_n clears the entry count and handshake state; no clearing pass
module sparse_triplet_accumulate #(
  parameter int ENTRIES = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sta_pkg::MODE_W-1:0]        in_mode,
  input  logic [sta_pkg::ROW_W-1:0]         in_row,
  input  logic [sta_pkg::ROW_W-1:0]         in_col,
  input  logic signed [sta_pkg::VAL_W-1:0]  in_value,
  input  logic [sta_pkg::IDX_W-1:0]         in_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sta_pkg::STAT_W-1:0]        out_status,
  output logic [sta_pkg::SLOT_W-1:0]        out_slot,
  output logic [sta_pkg::ROW_W-1:0]         out_row,
  output logic [sta_pkg::ROW_W-1:0]         out_col,
  output logic signed [sta_pkg::VAL_W-1:0]  out_value,
  output logic [sta_pkg::CNT_W-1:0]         out_entry_count
);
  import sta_pkg::*;

  // commands from the state machine, flags back from the datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller: idle, dispatch on mode, scan, then one result-load state per outcome
  sta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: operand latch, triplet memory, scan compare, adder, output register
  sta_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .in_index        (in_index),
    .cmd             (cmd),
    .status          (status),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_entry_count (out_entry_count)
  );

endmodule

// File: tb/sv/tb_sparse_triplet_accumulate.sv
`timescale 1ns / 1ps
// self-checking testbench for sparse_triplet_accumulate: a short directed table, then random
// append/add/subtract/read/clear traffic checked against a shadow copy of the triplet table
// depends on sta_pkg and the sparse_triplet_accumulate rtl
module tb_sparse_triplet_accumulate;
  import sta_pkg::*;

  localparam int     TABLE_DEPTH     = 128;
  localparam int     ITEMS_PER_PHASE = 485;
  // add/subtract on a full table is the slowest item, and this covers it
  localparam int     DRAIN_CYCLES    = 200;
  localparam longint CYCLE_LIMIT     = 3_000_000;

  // mode codes the block leaves unused
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         index;
  } triplet_op_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [SLOT_W-1:0]        slot;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic [CNT_W-1:0]         entry_count;
  } triplet_result_t;

  // typed = 1 means the result below is checked as written, else the shadow table decides
  typedef struct packed {
    triplet_op_t     op;
    logic            typed;
    triplet_result_t want;
  } directed_row_t;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode         = '0;
  logic [ROW_W-1:0]         in_row          = '0;
  logic [ROW_W-1:0]         in_col          = '0;
  logic signed [VAL_W-1:0]  in_value        = '0;
  logic [IDX_W-1:0]         in_index        = '0;
  logic                     out_valid;
  logic                     out_stall       = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic [SLOT_W-1:0]        out_slot;
  logic [ROW_W-1:0]         out_row;
  logic [ROW_W-1:0]         out_col;
  logic signed [VAL_W-1:0]  out_value;
  logic [CNT_W-1:0]         out_entry_count;

  // shadow copy of the triplet table
  logic [ROW_W-1:0]         shadow_row   [TABLE_DEPTH];
  logic [ROW_W-1:0]         shadow_col   [TABLE_DEPTH];
  logic [VAL_W-1:0]         shadow_value [TABLE_DEPTH];
  int                       shadow_count = 0;

  triplet_result_t          triplet_results_due [$];

  int     idle_pct       = 0;
  int     stall_pct      = 0;
  int     fail_count     = 0;
  int     transfers      = 0;
  int     results_seen   = 0;
  int     status_tally [4] = '{0, 0, 0, 0};
  longint cycle_count    = 0;

  int phase_idle  [4] = '{0, 75, 0, 9};
  int phase_stall [4] = '{0, 0, 75, 9};

  // directed walk: reads on an empty table, unused mode, wrap at both ends, negated
  // append on subtract, duplicate keys (first match wins), clear, read past the end
  directed_row_t directed_ops [22] = '{
    '{'{MODE_READ,    16'h0000, 16'h0000, 32'h0000_0000, 7'd0},   1'b1,
      '{STAT_BEYOND, 7'd0,   16'h0000, 16'h0000, 32'h0000_0000, 8'd0}},
    '{'{MODE_READ,    16'h0000, 16'h0000, 32'h0000_0000, 7'd127}, 1'b1,
      '{STAT_BEYOND, 7'd127, 16'h0000, 16'h0000, 32'h0000_0000, 8'd0}},
    '{'{MODE_SPARE_5, 16'hffff, 16'hffff, 32'hffff_ffff, 7'd127}, 1'b1,
      '{STAT_OK,     7'd0,   16'h0000, 16'h0000, 32'h0000_0000, 8'd0}},
    '{'{MODE_APPEND,  16'hffff, 16'hffff, 32'h7fff_ffff, 7'd0},   1'b1,
      '{STAT_OK,     7'd0,   16'hffff, 16'hffff, 32'h7fff_ffff, 8'd1}},
    '{'{MODE_ADD,     16'hffff, 16'hffff, 32'h0000_0001, 7'd0},   1'b1,
      '{STAT_MATCH,  7'd0,   16'hffff, 16'hffff, 32'h8000_0000, 8'd1}},
    '{'{MODE_SUB,     16'hffff, 16'hffff, 32'h0000_0001, 7'd0},   1'b1,
      '{STAT_MATCH,  7'd0,   16'hffff, 16'hffff, 32'h7fff_ffff, 8'd1}},
    '{'{MODE_SUB,     16'h0000, 16'h0000, 32'h8000_0000, 7'd0},   1'b1,
      '{STAT_OK,     7'd1,   16'h0000, 16'h0000, 32'h8000_0000, 8'd2}},
    '{'{MODE_ADD,     16'h0000, 16'hffff, 32'hffff_ffff, 7'd0},   1'b0, '0},
    '{'{MODE_APPEND,  16'h0000, 16'h0000, 32'h0000_0005, 7'd0},   1'b0, '0},
    '{'{MODE_ADD,     16'h0000, 16'h0000, 32'h0000_0003, 7'd0},   1'b0, '0},
    '{'{MODE_SUB,     16'hffff, 16'h0000, 32'h7fff_ffff, 7'd0},   1'b0, '0},
    '{'{MODE_SUB,     16'h0000, 16'hffff, 32'h8000_0000, 7'd0},   1'b0, '0},
    '{'{MODE_READ,    16'h0000, 16'h0000, 32'h0000_0000, 7'd3},   1'b0, '0},
    '{'{MODE_READ,    16'hffff, 16'hffff, 32'hffff_ffff, 7'd5},   1'b0, '0},
    '{'{MODE_SPARE_6, 16'h0000, 16'h0000, 32'h0000_0000, 7'd0},   1'b0, '0},
    '{'{MODE_SPARE_7, 16'h5a5a, 16'ha5a5, 32'h1234_5678, 7'd64},  1'b0, '0},
    '{'{MODE_CLEAR,   16'hffff, 16'hffff, 32'hffff_ffff, 7'd127}, 1'b1,
      '{STAT_OK,     7'd0,   16'h0000, 16'h0000, 32'h0000_0000, 8'd0}},
    '{'{MODE_READ,    16'h0000, 16'h0000, 32'h0000_0000, 7'd0},   1'b1,
      '{STAT_BEYOND, 7'd0,   16'h0000, 16'h0000, 32'h0000_0000, 8'd0}},
    '{'{MODE_ADD,     16'h1234, 16'h5678, 32'h0000_0000, 7'd0},   1'b0, '0},
    '{'{MODE_SUB,     16'h1234, 16'h5678, 32'hffff_fffb, 7'd0},   1'b0, '0},
    '{'{MODE_APPEND,  16'h8000, 16'h0001, 32'h8000_0000, 7'd0},   1'b0, '0},
    '{'{MODE_READ,    16'h0000, 16'h0000, 32'h0000_0000, 7'd1},   1'b0, '0}
  };

  sparse_triplet_accumulate dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_entry_count (out_entry_count)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // store a triplet at the end of the shadow table, or drop it when full
  function automatic triplet_result_t shadow_push(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                                  logic [VAL_W-1:0] value);
    triplet_result_t res;
    res = '0;
    if (shadow_count >= TABLE_DEPTH) begin
      res.status = STAT_FULL;
    end else begin
      shadow_row[shadow_count]   = row;
      shadow_col[shadow_count]   = col;
      shadow_value[shadow_count] = value;
      res.status = STAT_OK;
      res.slot   = SLOT_W'(shadow_count);
      res.row    = row;
      res.col    = col;
      res.value  = value;
      shadow_count++;
    end
    return res;
  endfunction

  // applies one operation to the shadow table and returns the result it should give
  function automatic triplet_result_t predict_triplet_op(triplet_op_t op);
    triplet_result_t res;
    int hit;
    res = '0;
    hit = -1;
    case (op.mode) inside
      MODE_APPEND: res = shadow_push(op.row, op.col, op.value);
      MODE_ADD, MODE_SUB: begin
        // first entry with the same key wins
        for (int j = 0; j < shadow_count; j++)
          if (hit < 0 && shadow_row[j] == op.row && shadow_col[j] == op.col) hit = j;
        if (hit < 0) begin
          res = shadow_push(op.row, op.col, (op.mode == MODE_SUB) ? -op.value : op.value);
        end else begin
          if (op.mode == MODE_ADD) shadow_value[hit] = shadow_value[hit] + op.value;
          else shadow_value[hit] = shadow_value[hit] - op.value;
          res.status = STAT_MATCH;
          res.slot   = SLOT_W'(hit);
          res.row    = shadow_row[hit];
          res.col    = shadow_col[hit];
          res.value  = shadow_value[hit];
        end
      end
      MODE_READ: begin
        res.slot = op.index;
        if (op.index < shadow_count) begin
          res.status = STAT_OK;
          res.row    = shadow_row[op.index];
          res.col    = shadow_col[op.index];
          res.value  = shadow_value[op.index];
        end else begin
          res.status = STAT_BEYOND;
        end
      end
      MODE_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.entry_count = CNT_W'(shadow_count);
    return res;
  endfunction

  // random operation: keys mostly taken from the table or a tiny pool so that
  // add/subtract actually hit, clear kept rare until the table has filled up
  function automatic triplet_op_t random_triplet_op();
    triplet_op_t op;
    int pick;
    int key_pick;
    int src;
    int clear_w;
    pick     = $urandom_range(0, 999);
    key_pick = $urandom_range(0, 99);
    clear_w  = (shadow_count == TABLE_DEPTH) ? 50 : 2;
    op.row   = ROW_W'($urandom);
    op.col   = ROW_W'($urandom);
    op.index = IDX_W'($urandom);
    case ($urandom_range(0, 9)) inside
      0:       op.value = 32'h8000_0000;
      1:       op.value = 32'h7fff_ffff;
      2:       op.value = 32'hffff_ffff;
      3, 4:    op.value = $urandom_range(0, 16) - 8;
      default: op.value = $urandom;
    endcase
    if (shadow_count > 0 && key_pick < 60) begin
      src    = $urandom_range(0, shadow_count - 1);
      op.row = shadow_row[src];
      op.col = shadow_col[src];
    end else if (key_pick < 75) begin
      op.row = ROW_W'($urandom_range(0, 3));
      op.col = ROW_W'($urandom_range(0, 3));
    end
    if (shadow_count > 0 && $urandom_range(0, 9) < 6)
      op.index = IDX_W'($urandom_range(0, shadow_count - 1));
    if (pick < clear_w) begin
      op.mode = MODE_CLEAR;
    end else if (pick < clear_w + 15) begin
      case ($urandom_range(0, 2))
        0:       op.mode = MODE_SPARE_5;
        1:       op.mode = MODE_SPARE_6;
        default: op.mode = MODE_SPARE_7;
      endcase
    end else if (pick < clear_w + 265) begin
      op.mode = MODE_APPEND;
    end else if (pick < clear_w + 565) begin
      op.mode = MODE_ADD;
    end else if (pick < clear_w + 795) begin
      op.mode = MODE_SUB;
    end else begin
      op.mode = MODE_READ;
    end
    return op;
  endfunction

  // one input transfer; idle cycles go in front, the payload holds until taken
  task automatic send_op(triplet_op_t op, logic use_typed, triplet_result_t typed_want);
    triplet_result_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode  <= op.mode;
    in_row   <= op.row;
    in_col   <= op.col;
    in_value <= op.value;
    in_index <= op.index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // the shadow table always follows, even where the result is typed in
    want = predict_triplet_op(op);
    if (use_typed) want = typed_want;
    triplet_results_due.push_back(want);
    status_tally[want.status]++;
    transfers++;
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    triplet_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (triplet_results_due.size() == 0) begin
        $error("result transfer with no prediction pending");
        fail_count++;
      end else begin
        want = triplet_results_due.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("slot", want.slot, out_slot);
        compare_field("row", want.row, out_row);
        compare_field("col", want.col, out_col);
        compare_field("value", want.value, out_value);
        compare_field("entry_count", want.entry_count, out_entry_count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               triplet_results_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // reset held low, released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i])
      send_op(directed_ops[i].op, directed_ops[i].typed, directed_ops[i].want);

    // random traffic under each idle/stall pattern
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = phase_idle[phase];
      stall_pct = phase_stall[phase];
      repeat (ITEMS_PER_PHASE) send_op(random_triplet_op(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    stall_pct = 0;
    while (triplet_results_due.size() != 0) @(posedge clk);
    // give a stray extra result time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transfers in, %0d results out, over no-idle, sender-idle, receiver-stall",
             transfers, results_seen);
    $display("and mixed phases: %0d matched updates, %0d full-table drops, %0d reads past count",
             status_tally[STAT_MATCH], status_tally[STAT_FULL], status_tally[STAT_BEYOND]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
